>>> hdl/spd_pkg.sv
// shared types, constants and functions for the stream packet deframer
package spd_pkg;

    localparam logic [5:0] POS_VERSION  = 6'd4;
    localparam logic [5:0] POS_TRACK    = 6'd5;
    localparam logic [5:0] POS_FLAGS    = 6'd6;
    localparam logic [5:0] POS_SEQ      = 6'd8;
    localparam logic [5:0] POS_PTS      = 6'd12;
    localparam logic [5:0] POS_DUR      = 6'd20;
    localparam logic [5:0] POS_LEN      = 6'd28;
    localparam logic [5:0] POS_CRC      = 6'd32;
    localparam logic [5:0] POS_RSVD     = 6'd36;
    localparam logic [5:0] POS_HDR_LAST = 6'd39;

    localparam logic [7:0]  FRAME_VERSION     = 8'd1;
    localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_SEQ_CHECK   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_MAGIC    = 3'd1,
        ST_BAD_VERSION  = 3'd2,
        ST_LEN_OVER     = 3'd3,
        ST_CRC_MISMATCH = 3'd4,
        ST_SEQ_GAP      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        packet_end;
        status_t     status;
        logic [7:0]  track_number;
        logic [7:0]  flag_bits;
        logic [31:0] sequence_number;
        logic [63:0] presentation_time;
        logic [63:0] duration_ticks;
        logic [31:0] payload_length;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] lane);
        logic [7:0] m;
        case (lane)
            2'd0:    m = 8'h41;
            2'd1:    m = 8'h55;
            2'd2:    m = 8'h53;
            default: m = 8'h31;
        endcase
        return m;
    endfunction

    // reflected crc-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/spd_parse.sv
// header capture, payload crc and packet status for one stream byte per step
module spd_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic [31:0]       max_payload_bytes,
    input  logic              seq_check_en,
    output logic              produce,
    output spd_pkg::result_t  result
);

    spd_pkg::phase_t  phase_reg;
    spd_pkg::phase_t  phase_next;
    logic [5:0]       hdr_pos_reg;
    logic             magic_ok_reg;
    logic             version_ok_reg;
    logic [31:0]      crc_reg;
    logic [31:0]      exp_seq_reg;
    logic [31:0]      remain_reg;
    logic [7:0]       track_reg;
    logic [7:0]       flags_reg;
    logic [31:0]      seq_reg;
    logic [63:0]      pts_reg;
    logic [63:0]      dur_reg;
    logic [31:0]      len_reg;
    logic [31:0]      exp_crc_reg;

    logic [31:0]      crc_upd;
    logic [31:0]      end_crc;
    logic             hdr_last;
    logic             len_over;
    logic             len_zero;
    logic             pay_last;
    logic             finish;
    spd_pkg::status_t fin_status;
    logic [5:0]       pts_off;
    logic [5:0]       dur_off;

    assign crc_upd  = spd_pkg::crc32_byte(crc_reg, byte_in);
    assign hdr_last = (hdr_pos_reg == spd_pkg::POS_HDR_LAST);
    assign len_over = (len_reg > max_payload_bytes);
    assign len_zero = (len_reg == 32'd0);
    assign pay_last = (remain_reg == 32'd1);
    assign end_crc  = (phase_reg == spd_pkg::PH_PAYLOAD) ? crc_upd : crc_reg;
    assign pts_off  = hdr_pos_reg - spd_pkg::POS_PTS;
    assign dur_off  = hdr_pos_reg - spd_pkg::POS_DUR;

    always_comb
    begin
        if (!magic_ok_reg)
            fin_status = spd_pkg::ST_BAD_MAGIC;
        else if (!version_ok_reg)
            fin_status = spd_pkg::ST_BAD_VERSION;
        else if (~end_crc != exp_crc_reg)
            fin_status = spd_pkg::ST_CRC_MISMATCH;
        else if (seq_check_en && (seq_reg != exp_seq_reg))
            fin_status = spd_pkg::ST_SEQ_GAP;
        else
            fin_status = spd_pkg::ST_OK;
    end

    assign finish = step &&
        (((phase_reg == spd_pkg::PH_HEADER) && hdr_last && !len_over && len_zero) ||
         ((phase_reg == spd_pkg::PH_PAYLOAD) && pay_last));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step) begin
            case (phase_reg)
                spd_pkg::PH_HEADER:
                begin
                    if (hdr_last) begin
                        if (len_over)
                            phase_next = spd_pkg::PH_HALTED;
                        else if (!len_zero)
                            phase_next = spd_pkg::PH_PAYLOAD;
                    end
                end
                spd_pkg::PH_PAYLOAD:
                begin
                    if (pay_last)
                        phase_next = spd_pkg::PH_HEADER;
                end
                spd_pkg::PH_HALTED:
                begin
                    phase_next = spd_pkg::PH_HALTED;
                end
                default:
                begin
                    phase_next = spd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // result of the current byte
    always_comb
    begin
        result  = '0;
        produce = 1'b0;
        case (phase_reg)
            spd_pkg::PH_HEADER:
            begin
                if (hdr_last && (len_over || len_zero)) begin
                    produce           = 1'b1;
                    result.packet_end = 1'b1;
                    result.status     = len_over ? spd_pkg::ST_LEN_OVER : fin_status;
                end
            end
            spd_pkg::PH_PAYLOAD:
            begin
                produce              = 1'b1;
                result.payload_valid = 1'b1;
                result.payload_byte  = byte_in;
                if (pay_last) begin
                    result.packet_end = 1'b1;
                    result.status     = fin_status;
                end
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
        if (result.packet_end) begin
            result.track_number      = track_reg;
            result.flag_bits         = flags_reg;
            result.sequence_number   = seq_reg;
            result.presentation_time = pts_reg;
            result.duration_ticks    = dur_reg;
            result.payload_length    = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= spd_pkg::PH_HEADER;
            hdr_pos_reg    <= '0;
            magic_ok_reg   <= 1'b1;
            version_ok_reg <= 1'b1;
            crc_reg        <= spd_pkg::CRC_INIT;
            exp_seq_reg    <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            if (phase_reg == spd_pkg::PH_HEADER) begin
                hdr_pos_reg <= hdr_last ? 6'd0 : hdr_pos_reg + 6'd1;
                if ((hdr_pos_reg < spd_pkg::POS_VERSION) &&
                    (byte_in != spd_pkg::magic_byte(hdr_pos_reg[1:0])))
                    magic_ok_reg <= 1'b0;
                if ((hdr_pos_reg == spd_pkg::POS_VERSION) &&
                    (byte_in != spd_pkg::FRAME_VERSION))
                    version_ok_reg <= 1'b0;
            end
            if (phase_reg == spd_pkg::PH_PAYLOAD)
                crc_reg <= pay_last ? spd_pkg::CRC_INIT : crc_upd;
            if (finish) begin
                magic_ok_reg   <= 1'b1;
                version_ok_reg <= 1'b1;
                if (fin_status == spd_pkg::ST_OK)
                    exp_seq_reg <= exp_seq_reg + 32'd1;
            end
        end
    end

    // header fields and payload count
    always_ff @(posedge clk)
    begin
        if (step) begin
            if (phase_reg == spd_pkg::PH_HEADER) begin
                if (hdr_pos_reg == spd_pkg::POS_TRACK)
                    track_reg <= byte_in;
                if (hdr_pos_reg == spd_pkg::POS_FLAGS)
                    flags_reg <= byte_in;
                if ((hdr_pos_reg >= spd_pkg::POS_SEQ) && (hdr_pos_reg < spd_pkg::POS_PTS))
                    seq_reg[{hdr_pos_reg[1:0], 3'b000} +: 8] <= byte_in;
                if ((hdr_pos_reg >= spd_pkg::POS_PTS) && (hdr_pos_reg < spd_pkg::POS_DUR))
                    pts_reg[{pts_off[2:0], 3'b000} +: 8] <= byte_in;
                if ((hdr_pos_reg >= spd_pkg::POS_DUR) && (hdr_pos_reg < spd_pkg::POS_LEN))
                    dur_reg[{dur_off[2:0], 3'b000} +: 8] <= byte_in;
                if ((hdr_pos_reg >= spd_pkg::POS_LEN) && (hdr_pos_reg < spd_pkg::POS_CRC))
                    len_reg[{hdr_pos_reg[1:0], 3'b000} +: 8] <= byte_in;
                if ((hdr_pos_reg >= spd_pkg::POS_CRC) && (hdr_pos_reg < spd_pkg::POS_RSVD))
                    exp_crc_reg[{hdr_pos_reg[1:0], 3'b000} +: 8] <= byte_in;
                if (hdr_last)
                    remain_reg <= len_reg;
            end else if (phase_reg == spd_pkg::PH_PAYLOAD) begin
                remain_reg <= remain_reg - 32'd1;
            end
        end
    end

endmodule

>>> hdl/stream_packet_deframer_core.sv
// an accepted beat waits in the input register until it can step, then its result is held in the output register
// throughput: one byte per cycle while result_stall stays low; header bytes give no result, but the last one
// closes a packet whose length is zero or over the limit; the byte-wide crc update and header capture sit between
// the input and result registers; reset clears control state; max_payload_bytes resets to 65536, sequence check off
// after a length over the limit all later bytes are dropped until reset
module stream_packet_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic        packet_end,
    output logic [2:0]  status,
    output logic [7:0]  track_number,
    output logic [7:0]  flag_bits,
    output logic [31:0] sequence_number,
    output logic [63:0] presentation_time,
    output logic [63:0] duration_ticks,
    output logic [31:0] payload_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    spd_pkg::result_t out_res_reg;
    logic [31:0]      max_payload_reg;
    logic             seq_check_reg;
    logic             step;
    logic             produce;
    spd_pkg::result_t res;

    assign cfg_ready  = 1'b1;
    assign step       = in_valid_reg && (!out_valid_reg || !result_stall);
    assign data_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_payload_reg <= spd_pkg::MAX_PAYLOAD_RESET;
            seq_check_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == spd_pkg::CFG_MAX_PAYLOAD)
                max_payload_reg <= cfg_data;
            if (cfg_index == spd_pkg::CFG_SEQ_CHECK)
                seq_check_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (data_valid && !data_stall) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
            in_byte_reg <= data_byte;
    end

    spd_parse u_parse (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .byte_in           (in_byte_reg),
        .max_payload_bytes (max_payload_reg),
        .seq_check_en      (seq_check_reg),
        .produce           (produce),
        .result            (res)
    );

    assign out_valid_next = (step && produce) ? 1'b1 : (result_stall && out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
            out_res_reg <= res;
    end

    assign result_valid      = out_valid_reg;
    assign payload_valid     = out_res_reg.payload_valid;
    assign payload_byte      = out_res_reg.payload_byte;
    assign packet_end        = out_res_reg.packet_end;
    assign status            = out_res_reg.status;
    assign track_number      = out_res_reg.track_number;
    assign flag_bits         = out_res_reg.flag_bits;
    assign sequence_number   = out_res_reg.sequence_number;
    assign presentation_time = out_res_reg.presentation_time;
    assign duration_ticks    = out_res_reg.duration_ticks;
    assign payload_length    = out_res_reg.payload_length;

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> (in_valid_reg && result_valid && result_stall))
        else $error("input stalled without a blocked result");

    a_produced_beat_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (step && produce) |=> (result_valid && (payload_byte == $past(res.payload_byte))))
        else $error("processed result not registered");

    a_taken_beat_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !(step && produce)) |=> !result_valid)
        else $error("result beat repeated after being taken");
`endif

endmodule

>>> test/stream_packet_deframer_core_checker.sv
// checker for the stream packet deframer: predicts every result beat and compares it
module stream_packet_deframer_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        payload_valid,
    input  logic [7:0]  payload_byte,
    input  logic        packet_end,
    input  logic [2:0]  status,
    input  logic [7:0]  track_number,
    input  logic [7:0]  flag_bits,
    input  logic [31:0] sequence_number,
    input  logic [63:0] presentation_time,
    input  logic [63:0] duration_ticks,
    input  logic [31:0] payload_length,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    localparam logic [31:0] MAGIC_WORD  = 32'h3153_5541;
    localparam int          MAX_REPORTS = 10;

    logic [31:0]     max_len;
    logic            seq_chk;

    longint unsigned byte_pos;
    logic            magic_ok;
    logic            version_ok;
    logic            halted;
    logic [7:0]      track_q;
    logic [7:0]      flags_q;
    logic [31:0]     seq_q;
    logic [63:0]     pts_q;
    logic [63:0]     dur_q;
    logic [31:0]     len_q;
    logic [31:0]     hdr_crc;
    logic [31:0]     run_crc;
    logic [31:0]     next_seq;

    spd_pkg::result_t predicted_beats[$];

    function automatic void check_field(input string fname, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t mismatch on %s: expected %0h, got %0h", $time, fname, want, got);
        end
    endfunction

    function automatic void add_beat(input spd_pkg::result_t r);
        predicted_beats = {predicted_beats, r};
    endfunction

    function automatic void fill_header(inout spd_pkg::result_t r,
                                        input spd_pkg::status_t st);
        r.packet_end        = 1'b1;
        r.status            = st;
        r.track_number      = track_q;
        r.flag_bits         = flags_q;
        r.sequence_number   = seq_q;
        r.presentation_time = pts_q;
        r.duration_ticks    = dur_q;
        r.payload_length    = len_q;
    endfunction

    function automatic void close_packet(inout spd_pkg::result_t r);
        spd_pkg::status_t st;
        if (!magic_ok)
            st = spd_pkg::ST_BAD_MAGIC;
        else if (!version_ok)
            st = spd_pkg::ST_BAD_VERSION;
        else if (~run_crc != hdr_crc)
            st = spd_pkg::ST_CRC_MISMATCH;
        else if (seq_chk && seq_q != next_seq)
            st = spd_pkg::ST_SEQ_GAP;
        else
            st = spd_pkg::ST_OK;
        fill_header(r, st);
        if (st == spd_pkg::ST_OK)
            next_seq = next_seq + 32'd1;
        byte_pos   = 0;
        magic_ok   = 1'b1;
        version_ok = 1'b1;
        run_crc    = spd_pkg::CRC_INIT;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        spd_pkg::result_t r;
        logic [5:0]       p;
        int               i;
        if (halted)
            return;
        r = '0;
        if (byte_pos <= spd_pkg::POS_HDR_LAST) begin
            p = byte_pos[5:0];
            if (p < spd_pkg::POS_VERSION) begin
                if (b != MAGIC_WORD[p*8 +: 8])
                    magic_ok = 1'b0;
            end else if (p == spd_pkg::POS_VERSION) begin
                if (b != spd_pkg::FRAME_VERSION)
                    version_ok = 1'b0;
            end else if (p == spd_pkg::POS_TRACK) begin
                track_q = b;
            end else if (p == spd_pkg::POS_FLAGS) begin
                flags_q = b;
            end else if (p >= spd_pkg::POS_SEQ && p < spd_pkg::POS_PTS) begin
                seq_q[(p - spd_pkg::POS_SEQ)*8 +: 8] = b;
            end else if (p >= spd_pkg::POS_PTS && p < spd_pkg::POS_DUR) begin
                pts_q[(p - spd_pkg::POS_PTS)*8 +: 8] = b;
            end else if (p >= spd_pkg::POS_DUR && p < spd_pkg::POS_LEN) begin
                dur_q[(p - spd_pkg::POS_DUR)*8 +: 8] = b;
            end else if (p >= spd_pkg::POS_LEN && p < spd_pkg::POS_CRC) begin
                len_q[(p - spd_pkg::POS_LEN)*8 +: 8] = b;
            end else if (p >= spd_pkg::POS_CRC && p < spd_pkg::POS_RSVD) begin
                hdr_crc[(p - spd_pkg::POS_CRC)*8 +: 8] = b;
            end
            if (p != spd_pkg::POS_HDR_LAST) begin
                byte_pos++;
                return;
            end
            // length checked first; over the limit, the parser stops for good
            if (len_q > max_len) begin
                fill_header(r, spd_pkg::ST_LEN_OVER);
                halted = 1'b1;
                add_beat(r);
                return;
            end
            if (len_q == 32'd0) begin
                close_packet(r);
                add_beat(r);
                return;
            end
            byte_pos++;
            return;
        end
        run_crc = run_crc ^ {24'd0, b};
        for (i = 0; i < 8; i++)
            run_crc = run_crc[0] ? ((run_crc >> 1) ^ spd_pkg::CRC_POLY) : (run_crc >> 1);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        if (byte_pos - spd_pkg::POS_HDR_LAST >= len_q)
            close_packet(r);
        else
            byte_pos++;
        add_beat(r);
    endfunction

    always @(posedge clk) begin : watch
        spd_pkg::result_t want;
        if (!rst_n) begin
            max_len    = spd_pkg::MAX_PAYLOAD_RESET;
            seq_chk    = 1'b0;
            byte_pos   = 0;
            magic_ok   = 1'b1;
            version_ok = 1'b1;
            halted     = 1'b0;
            track_q    = '0;
            flags_q    = '0;
            seq_q      = '0;
            pts_q      = '0;
            dur_q      = '0;
            len_q      = '0;
            hdr_crc    = '0;
            run_crc    = spd_pkg::CRC_INIT;
            next_seq   = '0;
            predicted_beats.delete();
            mismatches = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (predicted_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t unexpected beat: payload_valid %0b byte %0h end %0b status %0d",
                                 $time, payload_valid, payload_byte, packet_end, status);
                end else begin
                    want = predicted_beats.pop_front();
                    check_field("payload_valid", want.payload_valid, payload_valid);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("packet_end", want.packet_end, packet_end);
                    check_field("status", want.status, status);
                    check_field("track_number", want.track_number, track_number);
                    check_field("flag_bits", want.flag_bits, flag_bits);
                    check_field("sequence_number", want.sequence_number, sequence_number);
                    check_field("presentation_time", want.presentation_time, presentation_time);
                    check_field("duration_ticks", want.duration_ticks, duration_ticks);
                    check_field("payload_length", want.payload_length, payload_length);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == spd_pkg::CFG_MAX_PAYLOAD)
                    max_len = cfg_data;
                else
                    seq_chk = cfg_data[0];
            end
            if (data_valid && !data_stall)
                deframe_byte(data_byte);
        end
        pending = predicted_beats.size();
    end

endmodule

>>> test/stream_packet_deframer_core_test.sv
// top of the stream packet deframer testbench: clock, reset, packet stimulus and verdict
module stream_packet_deframer_core_test;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_BYTES  = 330;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [31:0] MAGIC_WORD    = 32'h3153_5541;

    localparam logic [3:0] DEF_NONE    = 4'b0000;
    localparam logic [3:0] DEF_MAGIC   = 4'b0001;
    localparam logic [3:0] DEF_VERSION = 4'b0010;
    localparam logic [3:0] DEF_CRC     = 4'b0100;
    localparam logic [3:0] DEF_SEQ     = 4'b1000;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct packed {
        logic [31:0] rsvd_word;
        logic [31:0] crc;
        logic [31:0] len;
        logic [63:0] dur;
        logic [63:0] pts;
        logic [31:0] seq;
        logic [7:0]  rsvd_byte;
        logic [7:0]  flags;
        logic [7:0]  track;
        logic [7:0]  version;
        logic [31:0] magic;
    } frame_hdr_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        data_valid   = 1'b0;
    logic [7:0]  data_byte    = 8'd0;
    logic        result_stall = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [31:0] cfg_data     = 32'd0;

    logic        data_stall;
    logic        result_valid;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [2:0]  status;
    logic [7:0]  track_number;
    logic [7:0]  flag_bits;
    logic [31:0] sequence_number;
    logic [63:0] presentation_time;
    logic [63:0] duration_ticks;
    logic [31:0] payload_length;
    logic        cfg_ready;

    int          mismatches;
    int          pending;
    int          cycles;
    int          sent_bytes;
    logic [31:0] next_seq;
    logic [31:0] limit;
    logic        seq_check_on;
    logic        steady;
    logic [7:0]  payload_bytes[$];

    stream_packet_deframer_core dut (.*);

    stream_packet_deframer_core_checker checker_i (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("stream_packet_deframer_core verification failed");
        $finish;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        forever begin
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 300 : 12)) @(posedge clk);
            result_stall <= 1'b1;
            repeat (1 + random_gap()) @(posedge clk);
            result_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] fill_byte(input fill_t fill);
        if (fill == FILL_ZERO)
            return 8'h00;
        if (fill == FILL_ONES)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] fill_word(input fill_t fill);
        if (fill == FILL_ZERO)
            return '0;
        if (fill == FILL_ONES)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] payload_crc();
        logic [31:0] c;
        c = '1;
        foreach (payload_bytes[k]) begin
            c = c ^ {24'd0, payload_bytes[k]};
            repeat (8) c = (c >> 1) ^ (c[0] ? spd_pkg::CRC_POLY : 32'd0);
        end
        return ~c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : random_gap();
        if (gap > 0) begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic drain();
        data_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == spd_pkg::CFG_SEQ_CHECK)
            seq_check_on = value[0];
        else
            limit = value;
    endtask

    // builds one packet with the given defects and sends header and payload
    task automatic run_frame(input logic [3:0] defects, input logic [31:0] len,
                             input fill_t fill);
        frame_hdr_t  h;
        logic [63:0] bits;
        int unsigned count;
        int          lane;
        int          k;
        payload_bytes.delete();
        // oversized lengths only get a short tail, the parser drops it anyway
        count = (len > 64) ? 24 : len;
        repeat (count) payload_bytes = {payload_bytes, fill_byte(fill)};
        bits        = fill_word(fill);
        h.track     = bits[7:0];
        h.flags     = bits[15:8];
        h.rsvd_byte = bits[23:16];
        h.rsvd_word = bits[63:32];
        h.pts       = fill_word(fill);
        h.dur       = fill_word(fill);
        h.len       = len;
        h.magic     = MAGIC_WORD;
        if ((defects & DEF_MAGIC) != 0) begin
            lane = $urandom_range(0, 3);
            h.magic[lane*8 +: 8] = h.magic[lane*8 +: 8] ^ 8'($urandom_range(1, 255));
        end
        h.version = spd_pkg::FRAME_VERSION;
        if ((defects & DEF_VERSION) != 0) begin
            h.version = fill_byte(fill);
            if (h.version == spd_pkg::FRAME_VERSION)
                h.version = 8'h00;
        end
        h.seq = next_seq;
        if ((defects & DEF_SEQ) != 0)
            h.seq = next_seq + 32'($urandom_range(1, 32'hFFFF_FFFE));
        h.crc = payload_crc();
        if ((defects & DEF_CRC) != 0)
            h.crc = h.crc ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
        for (k = 0; k < 40; k++)
            send_byte(h[k*8 +: 8]);
        foreach (payload_bytes[j])
            send_byte(payload_bytes[j]);
        if ((defects & (DEF_MAGIC | DEF_VERSION | DEF_CRC)) == 0
                && !((defects & DEF_SEQ) != 0 && seq_check_on))
            next_seq = next_seq + 32'd1;
    endtask

    initial begin : stimulus
        int          r;
        int unsigned cap;
        logic [3:0]  defects;
        logic [31:0] len;
        int          packets;
        next_seq     = '0;
        limit        = spd_pkg::MAX_PAYLOAD_RESET;
        seq_check_on = 1'b0;
        steady       = 1'b1;
        sent_bytes   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header extremes, empty payload, status priority, bad packets still framed
        run_frame(DEF_NONE, 0, FILL_ZERO);
        run_frame(DEF_NONE, 1, FILL_ONES);
        steady = 1'b0;
        run_frame(DEF_MAGIC, 2, FILL_RANDOM);
        run_frame(DEF_VERSION, 1, FILL_ZERO);
        run_frame(DEF_VERSION, 2, FILL_ONES);
        run_frame(DEF_MAGIC | DEF_VERSION | DEF_CRC, 3, FILL_RANDOM);
        run_frame(DEF_CRC, 3, FILL_RANDOM);
        run_frame(DEF_VERSION | DEF_CRC, 0, FILL_RANDOM);
        run_frame(DEF_SEQ, 2, FILL_RANDOM);
        write_register(spd_pkg::CFG_SEQ_CHECK, 32'd1);
        run_frame(DEF_SEQ, 1, FILL_RANDOM);
        run_frame(DEF_SEQ | DEF_CRC, 2, FILL_RANDOM);
        run_frame(DEF_NONE, 4, FILL_RANDOM);
        write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        run_frame(DEF_NONE, 5, FILL_RANDOM);
        write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'd3);
        run_frame(DEF_NONE, 3, FILL_RANDOM);
        write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'd0);
        run_frame(DEF_NONE, 0, FILL_RANDOM);
        run_frame(DEF_MAGIC, 0, FILL_RANDOM);
        write_register(spd_pkg::CFG_SEQ_CHECK, 32'd0);
        write_register(spd_pkg::CFG_MAX_PAYLOAD, spd_pkg::MAX_PAYLOAD_RESET);

        sent_bytes = 0;
        packets = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (packets % 3 == 2) begin
                write_register(spd_pkg::CFG_SEQ_CHECK, {31'd0, 1'($urandom_range(0, 1))});
                case ($urandom_range(0, 4))
                    0:       write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'd16);
                    1:       write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'd64);
                    2:       write_register(spd_pkg::CFG_MAX_PAYLOAD, spd_pkg::MAX_PAYLOAD_RESET);
                    3:       write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
                    default: write_register(spd_pkg::CFG_MAX_PAYLOAD, $urandom_range(16, 4096));
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                defects = DEF_NONE;
            else if (r < 78)
                defects = DEF_MAGIC;
            else if (r < 85)
                defects = DEF_VERSION;
            else if (r < 93)
                defects = DEF_CRC;
            else
                defects = DEF_SEQ;
            if ($urandom_range(0, 9) == 0)
                defects = defects | (DEF_MAGIC << $urandom_range(0, 3));
            cap = (limit < 64) ? limit : 64;
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 0;
            else if (r < 80)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(13, cap);
            steady = ($urandom_range(0, 4) == 0);
            run_frame(defects, len, FILL_RANDOM);
            packets++;
        end

        // length over the limit stops the parser; everything after it is dropped
        steady = 1'b0;
        write_register(spd_pkg::CFG_MAX_PAYLOAD, 32'd0);
        run_frame(DEF_NONE, 32'hFFFF_FFFF, FILL_RANDOM);
        run_frame(DEF_NONE, 2, FILL_RANDOM);
        write_register(spd_pkg::CFG_SEQ_CHECK, 32'd1);
        run_frame(DEF_NONE, 1, FILL_RANDOM);
        drain();

        if (mismatches == 0 && pending == 0)
            $display("stream_packet_deframer_core verification clean");
        else
            $display("stream_packet_deframer_core verification failed");
        $finish;
    end

endmodule
